FILE: design/dhks_pkg.sv
package dhks_pkg;

	localparam int CODE_W = 24;
	localparam int LEN_W  = 4;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_FIND   = 1'b1;

	typedef struct packed {
		logic              op;
		logic [CODE_W-1:0] seq_code;
		logic [LEN_W-1:0]  seq_len;
	} in_item_t;

	typedef struct packed {
		logic present;
		logic stored;
		logic table_full;
	} out_item_t;

endpackage

FILE: design/dhks_fifo.sv
module dhks_fifo
	import dhks_pkg::*;
#(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  T     wr_data,
	output logic full,
	input  logic rd,
	output T     rd_data,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	T                 entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> (!full || rd))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> !empty)
		else $error("queue read while empty");

endmodule

FILE: design/dhks_front.sv
module dhks_front
	import dhks_pkg::*;
#(
	parameter int  TABLE_SIZE = 4093,
	parameter int  MAX_LEN    = 12,
	parameter type job_t      = logic
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t item,
	output logic     busy,
	output logic     job_wr,
	output job_t     job,
	input  logic     job_full
);

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int KEY_W = $clog2(5 ** MAX_LEN);
	localparam logic [IDX_W+2:0] MOD_POS = (IDX_W + 3)'(TABLE_SIZE);
	localparam logic [IDX_W+2:0] MOD_STP = (IDX_W + 3)'(TABLE_SIZE - 1);

	typedef enum logic [1:0] {
		F_IDLE,
		F_HASH,
		F_SEND
	} front_state_t;

	// Residue of (r * 5 + d) for r below m; the sum stays below 5m.
	function automatic logic [IDX_W-1:0] mul5_mod(
		input logic [IDX_W-1:0] r,
		input logic [2:0]       d,
		input logic [IDX_W+2:0] m
	);
		logic [IDX_W+2:0] v;
		logic [IDX_W+2:0] m2;
		logic [IDX_W+2:0] m3;
		logic [IDX_W+2:0] m4;
		logic [IDX_W+2:0] sub;
		v  = ({3'b000, r} << 2) + {3'b000, r} + (IDX_W + 3)'(d);
		m2 = m << 1;
		m3 = m2 + m;
		m4 = m << 2;
		if (v >= m4) begin
			sub = m4;
		end else if (v >= m3) begin
			sub = m3;
		end else if (v >= m2) begin
			sub = m2;
		end else if (v >= m) begin
			sub = m;
		end else begin
			sub = '0;
		end
		return IDX_W'(v - sub);
	endfunction

	front_state_t      state_q;
	logic              op_q;
	logic [CODE_W-1:0] code_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [KEY_W-1:0]  key_q;
	logic [IDX_W-1:0]  rpos_q;
	logic [IDX_W-1:0]  rstp_q;

	logic [LEN_W-1:0]  len_c;
	logic [LEN_W-1:0]  digit_idx;
	logic [CODE_W-1:0] code_sh;
	logic [2:0]        digit;
	logic [KEY_W-1:0]  key_next;

	always_comb begin
		len_c     = (item.seq_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : item.seq_len;
		digit_idx = cnt_q - LEN_W'(1);
		// Bases past the end of the code word shift in as zero.
		code_sh   = code_q >> {digit_idx, 1'b0};
		digit     = {1'b0, code_sh[1:0]} + 3'd1;
		key_next  = KEY_W'(({3'b000, key_q} << 2) + {3'b000, key_q} + (KEY_W + 3)'(digit));
	end

	assign busy   = (state_q != F_IDLE);
	assign job_wr = (state_q == F_SEND) && !job_full;

	always_comb begin
		job.op   = op_q;
		job.nul  = (key_q == '0);
		job.key  = key_q;
		job.pos  = rpos_q;
		job.step = rstp_q + IDX_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_HASH;
						cnt_q   <= len_c;
					end
				end
				F_HASH: begin
					if (cnt_q == '0) begin
						state_q <= F_SEND;
					end else begin
						cnt_q <= digit_idx;
					end
				end
				F_SEND: begin
					if (!job_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && accept) begin
			op_q   <= item.op;
			code_q <= item.seq_code;
			key_q  <= '0;
			rpos_q <= '0;
			rstp_q <= '0;
		end else if (state_q == F_HASH && cnt_q != '0) begin
			key_q  <= key_next;
			rpos_q <= mul5_mod(rpos_q, digit, MOD_POS);
			rstp_q <= mul5_mod(rstp_q, digit, MOD_STP);
		end
	end

	a_residues_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != F_IDLE) |-> (rpos_q < IDX_W'(TABLE_SIZE)) && (rstp_q < IDX_W'(TABLE_SIZE - 1)))
		else $error("hash residue out of range");

endmodule

FILE: design/dhks_back.sv
module dhks_back
	import dhks_pkg::*;
#(
	parameter int  TABLE_SIZE = 4093,
	parameter int  MAX_LEN    = 12,
	parameter type job_t      = logic
) (
	input  logic      clk,
	input  logic      arst_n,
	output logic      clearing,
	input  job_t      job,
	input  logic      job_empty,
	output logic      job_rd,
	output logic      res_wr,
	output out_item_t res,
	input  logic      res_full
);

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int KEY_W = $clog2(5 ** MAX_LEN);

	typedef enum logic {
		B_IDLE,
		B_PROBE
	} back_state_t;

	back_state_t      state_q;
	logic             clearing_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] step_q;
	logic [IDX_W-1:0] probe_q;

	logic [KEY_W-1:0] slot_keys_q [TABLE_SIZE];
	logic [KEY_W-1:0] rd_key_q;

	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [KEY_W-1:0] mem_wd;
	logic             mem_re;
	logic [IDX_W-1:0] mem_ra;

	logic             start;
	logic             hit;
	logic             vacant;
	logic             last_probe;
	logic [IDX_W:0]   pos_sum;
	logic [IDX_W-1:0] pos_next;

	assign clearing = clearing_q;

	always_comb begin
		start      = (state_q == B_IDLE) && !clearing_q && !job_empty && !res_full;
		hit        = (rd_key_q == key_q);
		vacant     = (rd_key_q == '0);
		last_probe = (probe_q == IDX_W'(TABLE_SIZE - 1));
		pos_sum    = {1'b0, pos_q} + {1'b0, step_q};
		pos_next   = (pos_sum >= (IDX_W + 1)'(TABLE_SIZE))
			? IDX_W'(pos_sum - (IDX_W + 1)'(TABLE_SIZE)) : IDX_W'(pos_sum);

		job_rd = start;
		res_wr = 1'b0;
		res    = '0;
		mem_re = 1'b0;
		mem_ra = job.pos;
		mem_we = 1'b0;
		mem_wa = pos_q;
		mem_wd = key_q;

		if (clearing_q) begin
			mem_we = 1'b1;
			mem_wa = clr_idx_q;
			mem_wd = '0;
		end else if (start) begin
			if (job.nul) begin
				res_wr = 1'b1;
			end else begin
				mem_re = 1'b1;
			end
		end else if (state_q == B_PROBE) begin
			if (hit) begin
				res_wr      = 1'b1;
				res.present = 1'b1;
			end else if (vacant) begin
				res_wr     = 1'b1;
				res.stored = (op_q == OP_INSERT);
				mem_we     = (op_q == OP_INSERT);
			end else if (last_probe) begin
				res_wr         = 1'b1;
				res.table_full = 1'b1;
			end else begin
				mem_re = 1'b1;
				mem_ra = pos_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_keys_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_key_q <= slot_keys_q[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else begin
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
				if (clr_idx_q == IDX_W'(TABLE_SIZE - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			unique case (state_q)
				B_IDLE: begin
					if (start && !job.nul) begin
						state_q <= B_PROBE;
					end
				end
				B_PROBE: begin
					if (res_wr) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q    <= job.op;
			key_q   <= job.key;
			pos_q   <= job.pos;
			step_q  <= job.step;
			probe_q <= '0;
		end else if (state_q == B_PROBE && mem_re) begin
			pos_q   <= pos_next;
			probe_q <= probe_q + IDX_W'(1);
		end
	end

	a_clear_before_probe: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> (state_q == B_IDLE) && !res_wr && !job_rd)
		else $error("work started during the clearing pass");

	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_wr |-> ($countones({res.present, res.stored, res.table_full}) <= 1))
		else $error("result reports more than one outcome");

	a_store_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !clearing_q) |-> (mem_wd != '0) && res.stored)
		else $error("slot written without a stored key");

	a_read_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_PROBE) |-> $past(mem_re))
		else $error("probe compares stale read data");

endmodule

FILE: design/double_hash_key_set.sv
// Double-hashing key set for DNA sequences of one to MAX_LEN bases.
// Input channel: an item is pushed when push is high and full is low. It
// carries an operation (insert or find), the packed base codes and a length.
// Result channel: while empty is low, the oldest result sits on result and
// is taken when pop is high. Each item gives exactly one result: present,
// stored or table_full, or all zero for an empty sequence or a failed find.
// The front end turns one base per cycle into the base-5 key and both hash
// residues, and takes no new item until it has sent the last one as a job.
// A two-entry queue hands the job to the probe engine, which reads the start
// slot and then the slots along the stride, each probe being one read of the
// slot memory. A full table costs TABLE_SIZE probes.
// After reset the slot memory is swept to zero, one slot per cycle, and full
// stays high until the sweep is done and the first transaction can be taken.
// When the receiver stops popping, results collect in a two-entry queue,
// then the probe engine waits, then the job queue fills, and finally full
// stays high; no result is dropped or repeated. TABLE_SIZE must be a prime.
module double_hash_key_set
	import dhks_pkg::*;
#(
	parameter int TABLE_SIZE = 4093,
	parameter int MAX_LEN    = 12
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int KEY_W = $clog2(5 ** MAX_LEN);

	// A hashed job: the key with its start slot and probe stride. A null job
	// marks an empty sequence, which is answered without touching the table.
	typedef struct packed {
		logic             op;
		logic             nul;
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] pos;
		logic [IDX_W-1:0] step;
	} job_t;

	logic      front_busy;
	logic      clearing;
	logic      accept;

	logic      job_wr;
	job_t      job_in;
	logic      job_full;
	logic      job_rd;
	job_t      job_out;
	logic      job_empty;

	logic      res_wr;
	out_item_t res_in;
	logic      res_full;
	logic      res_rd;

	// The front end holds one item at a time, and nothing is taken while
	// the table is being cleared.
	assign full   = front_busy || clearing;
	assign accept = push && !full;
	assign res_rd = pop && !empty;

	dhks_front #(
		.TABLE_SIZE (TABLE_SIZE),
		.MAX_LEN    (MAX_LEN),
		.job_t      (job_t)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.busy     (front_busy),
		.job_wr   (job_wr),
		.job      (job_in),
		.job_full (job_full)
	);

	dhks_fifo #(
		.T     (job_t),
		.DEPTH (2)
	) u_job_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (job_wr),
		.wr_data (job_in),
		.full    (job_full),
		.rd      (job_rd),
		.rd_data (job_out),
		.empty   (job_empty)
	);

	dhks_back #(
		.TABLE_SIZE (TABLE_SIZE),
		.MAX_LEN    (MAX_LEN),
		.job_t      (job_t)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.job       (job_out),
		.job_empty (job_empty),
		.job_rd    (job_rd),
		.res_wr    (res_wr),
		.res       (res_in),
		.res_full  (res_full)
	);

	// Results wait here so the probe engine can move on while the receiver
	// stalls.
	dhks_fifo #(
		.T     (out_item_t),
		.DEPTH (2)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_wr),
		.wr_data (res_in),
		.full    (res_full),
		.rd      (res_rd),
		.rd_data (result),
		.empty   (empty)
	);

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> full)
		else $error("second transaction taken while hashing");

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full)
		else $error("transaction taken during the clearing pass");

endmodule
